>>> sv/bshc_pkg.sv
// Shared types, constants and register codes of the byte signature hit counter.
package bshc_pkg;

  // Geometry of the scan.
  localparam int LANES         = 4;
  localparam int MAX_SIG_BYTES = 5;
  localparam int BYTE_W        = 8;
  localparam int HIST_W        = BYTE_W * MAX_SIG_BYTES;
  localparam int LEN_W         = 3;
  localparam int HIT_W         = 2;
  localparam int SEEN_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 40;

  localparam logic [HIT_W-1:0]  HIT_SAT  = 2'd3;
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_SIG_BYTES);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd6;

  // Input item.
  typedef struct packed {
    logic [BYTE_W-1:0] rom_byte;
    logic              last_byte;
  } bshc_in_t;

  // Result item.
  typedef struct packed {
    logic [LANES-1:0] lane_found;
    logic             any_found;
  } bshc_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [LANES-1:0][HIST_W-1:0] pattern;
    logic [LANES*LEN_W-1:0]       lengths;
    logic [LANES*HIT_W-1:0]       min_hits;
    logic [LANES-1:0]             enable;
  } bshc_cfg_t;

  // Per-byte control handed to the lanes.
  typedef struct packed {
    logic step;   // a non-final byte updates the lane
    logic clear;  // the final byte ends the image
  } bshc_ctrl_t;

endpackage

>>> sv/bshc_cfg_regs.sv
// Configuration register file of the byte signature hit counter.
module bshc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bshc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bshc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bshc_pkg::bshc_cfg_t                 cfg
);
  import bshc_pkg::*;

  bshc_cfg_t cfg_r;
  bshc_cfg_t cfg_nxt;

  // Decode one register write; indexes beyond the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN0, REG_PATTERN1, REG_PATTERN2, REG_PATTERN3: begin
          cfg_nxt.pattern[cfg_index[1:0]] = cfg_data[HIST_W-1:0];
        end
        REG_LENGTHS: begin
          cfg_nxt.lengths = cfg_data[LANES*LEN_W-1:0];
        end
        REG_MIN_HITS: begin
          cfg_nxt.min_hits = cfg_data[LANES*HIT_W-1:0];
        end
        REG_ENABLE: begin
          cfg_nxt.enable = cfg_data[LANES-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/bshc_lane.sv
// One signature lane: window compare, hit counter and hold-off counter.
module bshc_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bshc_pkg::bshc_ctrl_t             ctrl,
  input  logic [bshc_pkg::HIST_W-1:0]      hist_nxt,
  input  logic [bshc_pkg::SEEN_W-1:0]      seen_nxt,
  input  logic [bshc_pkg::HIST_W-1:0]      pattern,
  input  logic [bshc_pkg::LEN_W-1:0]       len,
  output logic [bshc_pkg::HIT_W-1:0]       hit_count
);
  import bshc_pkg::*;

  logic [HIT_W-1:0]         hit_r, hit_nxt;
  logic [LEN_W-1:0]         hold_r, hold_nxt;
  logic [MAX_SIG_BYTES-1:0] match_len;
  logic                     match;
  logic                     len_ok;

  // Compare the newest l bytes against the first l signature bytes, for every l.
  // The oldest byte of the window lines up with signature byte 0.
  always_comb begin
    for (int l = 1; l <= MAX_SIG_BYTES; l++) begin
      match_len[l-1] = 1'b1;
      for (int k = 0; k < MAX_SIG_BYTES; k++) begin
        if (k < l) begin
          if (pattern[BYTE_W*k +: BYTE_W] !=
              hist_nxt[BYTE_W*((l - 1 - k + MAX_SIG_BYTES) % MAX_SIG_BYTES) +: BYTE_W]) begin
            match_len[l-1] = 1'b0;
          end
        end
      end
    end
  end

  // Pick the compare for the programmed length; a bad length never matches.
  always_comb begin
    match = 1'b0;
    for (int l = 1; l <= MAX_SIG_BYTES; l++) begin
      if (len == LEN_W'(l)) begin
        match = match_len[l-1];
      end
    end
  end

  assign len_ok = (len != '0) && (len <= LEN_W'(MAX_SIG_BYTES)) && (seen_nxt >= len);

  // Count a hit only outside the hold-off that follows the previous hit.
  always_comb begin
    hit_nxt  = hit_r;
    hold_nxt = hold_r;
    if (ctrl.clear) begin
      hit_nxt  = '0;
      hold_nxt = '0;
    end else if (ctrl.step) begin
      if (hold_r != '0) begin
        hold_nxt = hold_r - LEN_W'(1);
      end else if (len_ok && match) begin
        if (hit_r != HIT_SAT) begin
          hit_nxt = hit_r + HIT_W'(1);
        end
        hold_nxt = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= '0;
      hold_r <= '0;
    end else begin
      hit_r  <= hit_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign hit_count = hit_r;

  // The hold-off never runs longer than the longest signature.
  assert property (@(posedge clk) disable iff (!rst_n)
    hold_r <= LEN_W'(MAX_SIG_BYTES))
    else $error("hold-off exceeds the longest signature");

  // The end of an image leaves the lane cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (hit_r == '0) && (hold_r == '0))
    else $error("lane state not cleared after the final byte");

  // Between images the hit count only grows.
  assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.clear |=> hit_r >= $past(hit_r))
    else $error("hit count decreased within an image");

endmodule

>>> sv/byte_signature_hit_counter_unit.sv
// Top level of the byte signature hit counter: input register, history, lanes, result register.
// The result item is loaded as the final byte leaves the input register,
// which it does only while the result register is free or being taken.
// Throughput: one byte per cycle; only a final byte waits, while an untaken result blocks it.
// Reset (synchronous, rst_n low) clears configuration, history, hit counts and both valids.
// After each final byte the scan state returns to reset values; configuration is kept.
module byte_signature_hit_counter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bshc_pkg::bshc_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bshc_pkg::bshc_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [bshc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bshc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bshc_pkg::*;

  bshc_cfg_t                  cfg;
  bshc_ctrl_t                 ctrl;
  logic                       s1_vld_r, s1_vld_nxt;
  bshc_in_t                   s1_data_r;
  logic                       in_acc;
  logic                       adv;
  logic                       out_free;
  logic [HIST_W-1:0]          hist_r, hist_nxt;
  logic [SEEN_W-1:0]          seen_r, seen_nxt;
  logic [LANES-1:0][HIT_W-1:0] hit_count;
  logic [LANES-1:0]           found;
  logic                       out_vld_r;
  bshc_out_t                  out_data_r;

  // Configuration registers.
  bshc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: a held item moves on unless it is a final byte facing a full result register that is not being taken.
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = s1_vld_r && (!s1_data_r.last_byte || out_free);
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign s1_vld_nxt = in_acc || (s1_vld_r && !adv);

  assign ctrl.step  = adv && !s1_data_r.last_byte;
  assign ctrl.clear = adv && s1_data_r.last_byte;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  // Byte history, newest byte lowest, and the saturating count of bytes seen.
  assign hist_nxt = {hist_r[HIST_W-BYTE_W-1:0], s1_data_r.rom_byte};
  assign seen_nxt = (seen_r == SEEN_MAX) ? SEEN_MAX : seen_r + SEEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      seen_r <= '0;
    end else if (ctrl.clear) begin
      hist_r <= '0;
      seen_r <= '0;
    end else if (ctrl.step) begin
      hist_r <= hist_nxt;
      seen_r <= seen_nxt;
    end
  end

  // Signature lanes.
  for (genvar n = 0; n < LANES; n++) begin : g_lane
    bshc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .hist_nxt  (hist_nxt),
      .seen_nxt  (seen_nxt),
      .pattern   (cfg.pattern[n]),
      .len       (cfg.lengths[LEN_W*n +: LEN_W]),
      .hit_count (hit_count[n])
    );
  end

  // A lane is found when enabled and its count reached the required count.
  always_comb begin
    for (int n = 0; n < LANES; n++) begin
      found[n] = cfg.enable[n] && (hit_count[n] >= cfg.min_hits[HIT_W*n +: HIT_W]);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctrl.clear) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      out_data_r.lane_found <= found;
      out_data_r.any_found  <= |found;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A final byte always produces a result item in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> out_vld_r)
    else $error("final byte produced no result item");

  // Input is held back only while a final byte waits in the input register behind an untaken result item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && s1_data_r.last_byte && out_vld_r && out_stall)
    else $error("input stalled without a blocked final byte");

  // The byte count never passes the longest signature.
  assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SEEN_MAX)
    else $error("byte count exceeds the longest signature");

endmodule
